[hdl/pcrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrs_pkg
// types and constants shared by the prime count range sieve
// ----------------------------------------------------------------------------
package pcrs_pkg;

	localparam int NUM_W   = 16;
	localparam int COUNT_W = 17;
	localparam int PRIME_W = 8;
	localparam int SQ_W    = 2 * NUM_W;

	// numbers at or above this saturate to it minus one
	localparam int unsigned MAP_LIMIT = 65536;

	localparam logic [NUM_W-1:0] FIRST_PRIME = NUM_W'(2);

	// primes up to the square root of the largest root of a 16-bit bound
	localparam int SMALL_PRIMES = 6;

	typedef struct packed {
		logic             vld;
		logic [NUM_W-1:0] num;
		logic             comp;
		logic             claimed;
		logic             low;
		logic             last;
	} tok_t;

endpackage

[hdl/pcrs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrs_cell
// one sieve cell: holds a base prime and the residue of the passing candidate
// ----------------------------------------------------------------------------
module pcrs_cell #(
	parameter bit LOW_ONLY = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  pcrs_pkg::tok_t tok_in,
	output pcrs_pkg::tok_t tok_out
);

	logic                         full_q;
	logic [pcrs_pkg::PRIME_W-1:0] p_q;
	logic [pcrs_pkg::PRIME_W-1:0] r_q;
	logic [pcrs_pkg::PRIME_W-1:0] r_nxt;
	logic                         hit;
	logic                         claim;
	pcrs_pkg::tok_t               tok_nxt;
	pcrs_pkg::tok_t               tok_q;

	assign r_nxt = (r_q == p_q - pcrs_pkg::PRIME_W'(1)) ? '0 : r_q + pcrs_pkg::PRIME_W'(1);
	assign hit   = full_q && (r_nxt == '0) && (!LOW_ONLY || tok_in.low);
	assign claim = !full_q && tok_in.vld && !tok_in.comp && !tok_in.claimed
		&& (tok_in.num[pcrs_pkg::NUM_W-1:pcrs_pkg::PRIME_W] == '0);

	always_comb begin
		tok_nxt         = tok_in;
		tok_nxt.comp    = tok_in.comp | (tok_in.vld & hit);
		tok_nxt.claimed = tok_in.claimed | claim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (clear) begin
			full_q <= 1'b0;
		end else if (claim) begin
			full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			if (full_q) begin
				r_q <= r_nxt;
			end else if (claim) begin
				p_q <= tok_in.num[pcrs_pkg::PRIME_W-1:0];
				r_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

[hdl/pcrs_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrs_chain
// row of sieve cells that candidates walk through one cell per cycle
// ----------------------------------------------------------------------------
module pcrs_chain #(
	parameter int BASE_PRIME_SLOTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clear,
	input  pcrs_pkg::tok_t tok_in,
	output pcrs_pkg::tok_t tok_out
);

	localparam int CELLS = (BASE_PRIME_SLOTS > pcrs_pkg::SMALL_PRIMES) ?
		BASE_PRIME_SLOTS : pcrs_pkg::SMALL_PRIMES;

	pcrs_pkg::tok_t tok_w [0:CELLS];

	assign tok_w[0] = tok_in;

	// cells past the slot count only sieve numbers up to the root
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		pcrs_cell #(
			.LOW_ONLY (i >= BASE_PRIME_SLOTS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clear   (clear),
			.tok_in  (tok_w[i]),
			.tok_out (tok_w[i+1])
		);
	end

	assign tok_out = tok_w[CELLS];

endmodule

[hdl/prime_count_range_sieve.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_count_range_sieve
// counts the primes in a closed range with a row of sieve cells
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Candidates from 2
// up to range_high enter the cell row one per cycle; each cell keeps one base
// prime below 256 with a running residue and flags multiples as they pass.
// A request is done when its last candidate leaves the end of the row. An
// inverted or empty range skips the row, and done rises in the cycle after
// acceptance. The result is shown on prime_count and range_error for one
// cycle with done high; it cannot be held off, so the receiver must capture
// it then.
module prime_count_range_sieve #(
	parameter int BASE_PRIME_SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [pcrs_pkg::NUM_W-1:0]   range_low,
	input  logic [pcrs_pkg::NUM_W-1:0]   range_high,
	output logic                         done,
	output logic [pcrs_pkg::COUNT_W-1:0] prime_count,
	output logic                         range_error
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                   state_q;
	logic [pcrs_pkg::NUM_W-1:0]   num_q;
	logic [pcrs_pkg::NUM_W-1:0]   lo_q;
	logic [pcrs_pkg::NUM_W-1:0]   hi_q;
	logic [pcrs_pkg::SQ_W-1:0]    sq_q;
	logic [pcrs_pkg::COUNT_W-1:0] count_q;
	logic                         done_q;
	logic [pcrs_pkg::COUNT_W-1:0] pc_q;
	logic                         err_q;

	logic                         accept;
	logic [pcrs_pkg::NUM_W-1:0]   hi_sat;
	logic                         inverted;
	logic                         empty;
	logic                         run_go;
	logic                         add;
	pcrs_pkg::tok_t               src_tok;
	pcrs_pkg::tok_t               ex_tok;

	assign accept   = start && (state_q == ST_IDLE);
	assign inverted = range_low > range_high;
	assign hi_sat   = (32'(range_high) > pcrs_pkg::MAP_LIMIT - 1) ?
		pcrs_pkg::NUM_W'(pcrs_pkg::MAP_LIMIT - 1) : range_high;
	assign empty    = (range_low > hi_sat) || (hi_sat < pcrs_pkg::FIRST_PRIME);
	assign run_go   = accept && !inverted && !empty;

	// candidate source
	always_comb begin
		src_tok         = '0;
		src_tok.vld     = (state_q == ST_RUN);
		src_tok.num     = num_q;
		src_tok.low     = sq_q <= pcrs_pkg::SQ_W'(hi_q);
		src_tok.last    = num_q == hi_q;
	end

	pcrs_chain #(
		.BASE_PRIME_SLOTS (BASE_PRIME_SLOTS)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (run_go),
		.tok_in  (src_tok),
		.tok_out (ex_tok)
	);

	assign add = ex_tok.vld && !ex_tok.comp && (ex_tok.num >= lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (run_go) begin
							state_q <= ST_RUN;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (num_q == hi_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (ex_tok.vld && ex_tok.last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q    <= range_low;
			hi_q    <= hi_sat;
			num_q   <= pcrs_pkg::FIRST_PRIME;
			sq_q    <= pcrs_pkg::SQ_W'(pcrs_pkg::FIRST_PRIME) * pcrs_pkg::SQ_W'(pcrs_pkg::FIRST_PRIME);
			count_q <= '0;
			pc_q    <= '0;
			err_q   <= inverted;
		end else begin
			if (state_q == ST_RUN) begin
				num_q <= num_q + pcrs_pkg::NUM_W'(1);
				sq_q  <= sq_q + pcrs_pkg::SQ_W'({num_q, 1'b1});
			end
			count_q <= count_q + pcrs_pkg::COUNT_W'(add);
			if (state_q == ST_DRAIN && ex_tok.vld && ex_tok.last) begin
				pc_q <= count_q + pcrs_pkg::COUNT_W'(add);
			end
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign done        = done_q;
	assign prime_count = pc_q;
	assign range_error = err_q;

endmodule

[verif/prime_count_range_sieve_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_count_range_sieve_test
// self-checking bench for the range prime counter
// ----------------------------------------------------------------------------
// Requests go in on the start/busy handshake. Each accepted transaction gets
// its expected count either from a table of known answers or from a sieve
// kept in the bench. Every done strobe is compared with the oldest
// expectation. A short table of edge ranges runs first. Random ranges follow:
// mostly small bounds, a few near the top of the 16-bit range, and some
// inverted ones. The sender's gap rate changes between phases.
// ----------------------------------------------------------------------------
module prime_count_range_sieve_test;

	localparam int SLOT_COUNT   = 64;
	localparam int RANDOM_ITEMS = 76;
	localparam int PROBE_ROWS   = 24;

	typedef struct packed {
		logic [pcrs_pkg::NUM_W-1:0]   lo;
		logic [pcrs_pkg::NUM_W-1:0]   hi;
		logic                         known;
		logic [pcrs_pkg::COUNT_W-1:0] cnt;
		logic                         err;
	} probe_row_t;

	typedef struct packed {
		logic [pcrs_pkg::NUM_W-1:0]   lo;
		logic [pcrs_pkg::NUM_W-1:0]   hi;
		logic [pcrs_pkg::COUNT_W-1:0] cnt;
		logic                         err;
	} tally_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [pcrs_pkg::NUM_W-1:0]   range_low;
	logic [pcrs_pkg::NUM_W-1:0]   range_high;
	logic                         done;
	logic [pcrs_pkg::COUNT_W-1:0] prime_count;
	logic                         range_error;

	// known answer travelling with the transaction
	logic                         req_known;
	logic [pcrs_pkg::COUNT_W-1:0] req_cnt;
	logic                         req_err;

	logic [pcrs_pkg::MAP_LIMIT-1:0] composite_bits;
	logic [pcrs_pkg::PRIME_W-1:0]   base_slots [SLOT_COUNT];
	tally_t                         awaited_tallies [$];
	int unsigned                    gap_pct;
	int                             mismatches = 0;

	probe_row_t probe_rows [PROBE_ROWS] = '{
		'{16'd0,     16'd0,     1'b1, 17'd0,    1'b0},
		'{16'd0,     16'd1,     1'b1, 17'd0,    1'b0},
		'{16'd1,     16'd1,     1'b1, 17'd0,    1'b0},
		'{16'd2,     16'd2,     1'b1, 17'd1,    1'b0},
		'{16'd0,     16'd2,     1'b1, 17'd1,    1'b0},
		'{16'd1,     16'd0,     1'b1, 17'd0,    1'b1},
		'{16'd65535, 16'd0,     1'b1, 17'd0,    1'b1},
		'{16'd65535, 16'd65534, 1'b1, 17'd0,    1'b1},
		'{16'd0,     16'd65535, 1'b1, 17'd6542, 1'b0},
		'{16'd65535, 16'd65535, 1'b1, 17'd0,    1'b0},
		'{16'd65521, 16'd65535, 1'b1, 17'd1,    1'b0},
		'{16'd3,     16'd3,     1'b1, 17'd1,    1'b0},
		'{16'd4,     16'd4,     1'b1, 17'd0,    1'b0},
		'{16'd0,     16'd10,    1'b1, 17'd4,    1'b0},
		'{16'd0,     16'd100,   1'b1, 17'd25,   1'b0},
		'{16'd10,    16'd20,    1'b0, 17'd0,    1'b0},
		'{16'd0,     16'd169,   1'b0, 17'd0,    1'b0},
		'{16'd121,   16'd121,   1'b0, 17'd0,    1'b0},
		'{16'd0,     16'd255,   1'b0, 17'd0,    1'b0},
		'{16'd255,   16'd257,   1'b0, 17'd0,    1'b0},
		'{16'd32768, 16'd33023, 1'b0, 17'd0,    1'b0},
		'{16'd65280, 16'd65535, 1'b0, 17'd0,    1'b0},
		'{16'd2,     16'd4,     1'b0, 17'd0,    1'b0},
		'{16'd0,     16'd3,     1'b0, 17'd0,    1'b0}
	};

	prime_count_range_sieve #(
		.BASE_PRIME_SLOTS(SLOT_COUNT)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.range_low  (range_low),
		.range_high (range_high),
		.done       (done),
		.prime_count(prime_count),
		.range_error(range_error)
	);

	always #10 clk = ~clk;

	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// segmented sieve: base primes up to the root, then multiples above it
	function automatic void count_primes_in_range(
		input  logic [pcrs_pkg::NUM_W-1:0]   lo_in,
		input  logic [pcrs_pkg::NUM_W-1:0]   hi_in,
		output logic [pcrs_pkg::COUNT_W-1:0] cnt,
		output logic                         err
	);
		int unsigned lo, hi, root, i, j, k, left, p, total;
		lo  = 32'(lo_in);
		hi  = 32'(hi_in);
		cnt = '0;
		err = 1'b0;
		if (lo > hi) begin
			err = 1'b1;
			return;
		end
		if (hi > pcrs_pkg::MAP_LIMIT - 1)
			hi = pcrs_pkg::MAP_LIMIT - 1;
		if (lo > hi)
			return;
		composite_bits    = '0;
		composite_bits[0] = 1'b1;
		composite_bits[1] = 1'b1;
		root = 0;
		while ((root + 1) * (root + 1) <= hi)
			root++;
		k = 0;
		for (i = 32'(pcrs_pkg::FIRST_PRIME); i <= root; i++) begin
			if (composite_bits[i])
				continue;
			if (k < SLOT_COUNT) begin
				base_slots[k] = pcrs_pkg::PRIME_W'(i);
				k++;
			end
			if (i * i <= root)
				for (j = 2 * i; j <= root; j += i)
					composite_bits[j] = 1'b1;
		end
		left = root + 1;
		if (lo > left)
			left = lo;
		for (i = 0; i < k; i++) begin
			p = 32'(base_slots[i]);
			if (p < 32'(pcrs_pkg::FIRST_PRIME))
				continue;
			for (j = left + (p - left % p) % p; j <= hi; j += p)
				composite_bits[j] = 1'b1;
		end
		total = 0;
		for (i = lo; i <= hi; i++)
			if (!composite_bits[i])
				total++;
		cnt = pcrs_pkg::COUNT_W'(total);
	endfunction

	// transaction capture and result checking
	always @(posedge clk) begin : watch
		tally_t                       got;
		logic [pcrs_pkg::COUNT_W-1:0] c;
		logic                         e;
		if (arst_n) begin
			if (done) begin
				if (awaited_tallies.size() == 0) begin
					flag_mismatch($sformatf("result count=%0d err=%0b with none pending",
						prime_count, range_error));
				end else begin
					got = awaited_tallies.pop_front();
					if (prime_count !== got.cnt)
						flag_mismatch($sformatf("[%0d,%0d] count %0d, expected %0d",
							got.lo, got.hi, prime_count, got.cnt));
					if (range_error !== got.err)
						flag_mismatch($sformatf("[%0d,%0d] range_error %b, expected %b",
							got.lo, got.hi, range_error, got.err));
				end
			end
			if (start && !busy) begin
				if (req_known) begin
					c = req_cnt;
					e = req_err;
				end else begin
					count_primes_in_range(range_low, range_high, c, e);
				end
				awaited_tallies.push_back('{range_low, range_high, c, e});
			end
		end
	end

	task automatic issue(
		input logic [pcrs_pkg::NUM_W-1:0]   lo,
		input logic [pcrs_pkg::NUM_W-1:0]   hi,
		input logic                         known,
		input logic [pcrs_pkg::COUNT_W-1:0] cnt,
		input logic                         err
	);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		range_low  <= lo;
		range_high <= hi;
		req_known  <= known;
		req_cnt    <= cnt;
		req_err    <= err;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		int                         n;
		int unsigned                pick;
		logic [pcrs_pkg::NUM_W-1:0] lo, hi;
		arst_n     <= 1'b0;
		start      <= 1'b0;
		range_low  <= '0;
		range_high <= '0;
		req_known  <= 1'b0;
		req_cnt    <= '0;
		req_err    <= 1'b0;
		gap_pct    = 19;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < PROBE_ROWS; n++)
			issue(probe_rows[n].lo, probe_rows[n].hi, probe_rows[n].known,
				probe_rows[n].cnt, probe_rows[n].err);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3)
				gap_pct = 51;
			else if (n == 2 * RANDOM_ITEMS / 3)
				gap_pct = 0;
			pick = $urandom_range(99);
			if (n % 20 == 7) begin
				// a few near the top of the range, these are slow
				hi = pcrs_pkg::NUM_W'($urandom_range(65535, 49152));
				lo = (pick < 50) ? pcrs_pkg::NUM_W'($urandom_range(32'(hi))) :
					hi - pcrs_pkg::NUM_W'($urandom_range(300));
			end else if (pick < 20) begin
				lo = pcrs_pkg::NUM_W'($urandom_range(65535, 1));
				hi = pcrs_pkg::NUM_W'($urandom_range(32'(lo) - 1));
			end else begin
				hi = (pick < 35) ? pcrs_pkg::NUM_W'($urandom_range(4095)) :
					pcrs_pkg::NUM_W'($urandom_range(511));
				case (pick % 4)
					0: lo = pcrs_pkg::NUM_W'($urandom_range(3));
					1: lo = hi;
					default: lo = pcrs_pkg::NUM_W'($urandom_range(32'(hi)));
				endcase
			end
			issue(lo, hi, 1'b0, '0, 1'b0);
		end
		start <= 1'b0;

		while (awaited_tallies.size() != 0)
			@(posedge clk);
		repeat (4 * SLOT_COUNT) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
hdl/pcrs_pkg.sv
hdl/pcrs_cell.sv
hdl/pcrs_chain.sv
hdl/prime_count_range_sieve.sv
verif/prime_count_range_sieve_test.sv
